// File: src/sphere_strip_index_generator_unit_defines.svh
// assertion helpers for the rtl file sphere_strip_index_generator_unit.sv
`ifndef SPHERE_STRIP_INDEX_GENERATOR_UNIT_DEFINES_SVH
`define SPHERE_STRIP_INDEX_GENERATOR_UNIT_DEFINES_SVH

// checked only while out of reset
`define SSIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SSIG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ssig_pkg.sv
package ssig_pkg;

  localparam int CFG_W     = 9;
  localparam int IDX_W     = 17;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    PH_LEAD_TOP = 3'd0,
    PH_LEAD_BOT = 3'd1,
    PH_PAIR_TOP = 3'd2,
    PH_PAIR_BOT = 3'd3,
    PH_DEG_REP  = 3'd4,
    PH_DEG_NEXT = 3'd5
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURED_MODE = 2'd2;

  localparam logic [CFG_W-1:0] RST_SLICE_COUNT   = 9'd16;
  localparam logic [CFG_W-1:0] RST_LOOP_COUNT    = 9'd16;
  localparam logic             RST_TEXTURED_MODE = 1'b1;

  localparam logic [CFG_W-1:0] MIN_SLICES = 9'd3;
  localparam logic [CFG_W-1:0] MIN_LOOPS  = 9'd4;

  // clamped geometry as seen by the index logic
  typedef struct packed {
    logic [CFG_W-1:0] slices;
    logic [CFG_W-1:0] loops;
    logic             textured;
  } geom_t;

endpackage

// File: src/ssig_step.sv
module ssig_step
  import ssig_pkg::*;
#(
  parameter int ROW_W = 8,
  parameter int COL_W = 9
) (
  input  geom_t            geom,
  input  logic             restart,
  input  logic [ROW_W-1:0] row_r,
  input  logic [COL_W-1:0] col_r,
  input  phase_t           phase_r,
  input  logic [IDX_W-1:0] prev_r,
  input  logic [IDX_W-1:0] base_r,
  output logic [ROW_W-1:0] row_nxt,
  output logic [COL_W-1:0] col_nxt,
  output phase_t           phase_nxt,
  output logic [IDX_W-1:0] prev_nxt,
  output logic [IDX_W-1:0] base_nxt,
  output logic [IDX_W-1:0] vidx,
  output logic             last
);

  localparam int CW  = (COL_W > CFG_W) ? COL_W : CFG_W;
  localparam int RCW = CFG_W + 1;

  function automatic logic [IDX_W-1:0] top_at(input logic tex, input logic [CFG_W-1:0] s,
                                               input logic last_band, input logic first_band,
                                               input logic [IDX_W-1:0] base,
                                               input logic [COL_W-1:0] c);
    logic [IDX_W-1:0] res;
    if (tex) begin
      res = base + IDX_W'(s) + IDX_W'(1) + IDX_W'(c);
    end else if (last_band) begin
      res = IDX_W'(1);
    end else if (first_band) begin
      res = IDX_W'(2) + IDX_W'(c);
    end else begin
      res = base + IDX_W'(s) + IDX_W'(c);
    end
    return res;
  endfunction

  logic [ROW_W-1:0] row_c;
  logic [COL_W-1:0] col_c;
  phase_t           ph_c;
  logic [IDX_W-1:0] prev_c;
  logic [IDX_W-1:0] base_c;
  logic             go_start;
  logic             first_band;
  logic             last_band;
  logic             last_band_n;
  logic [COL_W-1:0] col_inc;
  logic             col_wrap;
  logic [COL_W-1:0] n_col;
  logic [IDX_W-1:0] bot_n;
  logic [IDX_W-1:0] base_step;

  always_comb begin
    // unused phase codes behave like a restart
    go_start = restart || (phase_r > PH_DEG_NEXT);
    row_c  = go_start ? '0 : row_r;
    col_c  = go_start ? '0 : col_r;
    ph_c   = go_start ? PH_LEAD_TOP : phase_r;
    prev_c = go_start ? '0 : prev_r;
    base_c = go_start ? '0 : base_r;

    first_band  = (row_c == '0);
    last_band   = (RCW'(row_c) + RCW'(2)) >= RCW'(geom.loops);
    last_band_n = (RCW'(row_c) + RCW'(3)) >= RCW'(geom.loops);

    col_inc  = col_c + COL_W'(1);
    col_wrap = CW'(col_inc) >= CW'(geom.slices);
    n_col    = (!geom.textured && col_wrap) ? '0 : col_inc;

    bot_n = (!geom.textured && first_band) ? '0 : base_c + IDX_W'(n_col);
    if (geom.textured) begin
      base_step = base_c + IDX_W'(geom.slices) + IDX_W'(1);
    end else if (first_band) begin
      base_step = IDX_W'(2);
    end else begin
      base_step = base_c + IDX_W'(geom.slices);
    end

    row_nxt   = row_c;
    col_nxt   = col_c;
    phase_nxt = ph_c;
    base_nxt  = base_c;
    vidx      = prev_c;
    last      = 1'b0;

    unique case (ph_c)
      PH_LEAD_TOP: begin
        vidx      = top_at(geom.textured, geom.slices, last_band, first_band, base_c, '0);
        phase_nxt = PH_LEAD_BOT;
      end
      PH_LEAD_BOT: begin
        vidx      = (!geom.textured && first_band) ? '0 : base_c;
        col_nxt   = '0;
        phase_nxt = PH_PAIR_TOP;
      end
      PH_PAIR_TOP: begin
        vidx      = top_at(geom.textured, geom.slices, last_band, first_band, base_c, n_col);
        phase_nxt = PH_PAIR_BOT;
      end
      PH_PAIR_BOT: begin
        vidx    = bot_n;
        col_nxt = col_inc;
        if (col_wrap) begin
          if (last_band) begin
            last = 1'b1;
          end else begin
            phase_nxt = PH_DEG_REP;
          end
        end else begin
          phase_nxt = PH_PAIR_TOP;
        end
      end
      PH_DEG_REP: begin
        vidx      = prev_c;
        phase_nxt = PH_DEG_NEXT;
      end
      PH_DEG_NEXT: begin
        // step into the next band and emit its lead top
        base_nxt  = base_step;
        row_nxt   = row_c + ROW_W'(1);
        col_nxt   = '0;
        vidx      = top_at(geom.textured, geom.slices, last_band_n, 1'b0, base_step, '0);
        phase_nxt = PH_LEAD_TOP;
      end
      default: begin
        vidx      = top_at(geom.textured, geom.slices, last_band, first_band, base_c, '0);
        phase_nxt = PH_LEAD_BOT;
      end
    endcase

    prev_nxt = vidx;
    // strip done: the next request begins again
    if (last) begin
      row_nxt   = '0;
      col_nxt   = '0;
      phase_nxt = PH_LEAD_TOP;
      prev_nxt  = '0;
      base_nxt  = '0;
    end
  end

endmodule

// File: src/sphere_strip_index_generator_unit.sv
// an accepted input beat passes through the input register, then the output register
// one index per cycle unless out_tready stalls, set by the counter update in ssig_step
// the input register refills in the same cycle its content moves to the output register
// reset (synchronous, rst_n low): registers back to 16 slices, 16 loops, textured mode,
// sequence at its first index, both pipeline registers empty
`include "sphere_strip_index_generator_unit_defines.svh"
module sphere_strip_index_generator_unit
  import ssig_pkg::*;
#(
  parameter int MAX_SLICES = 256,
  parameter int MAX_LOOPS  = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] restart, [7:1] zero
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [16:0] vertex_index, [23:17] zero
  output logic                 out_tlast,  // last_index
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int SMAX    = (MAX_SLICES < CFG_MAX) ? MAX_SLICES : CFG_MAX;
  localparam int LMAX    = (MAX_LOOPS < CFG_MAX) ? MAX_LOOPS : CFG_MAX;
  localparam int ROW_W   = $clog2(LMAX);
  localparam int COL_W   = $clog2(SMAX + 1);
  localparam int CW      = (COL_W > CFG_W) ? COL_W : CFG_W;

  logic [CFG_W-1:0] slice_cnt_r;
  logic [CFG_W-1:0] loop_cnt_r;
  logic             textured_r;
  geom_t            geom;

  logic             in_valid_r;
  logic             restart_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] vidx_r;
  logic             last_r;
  logic             advance;
  logic             cfg_hit;

  logic [ROW_W-1:0] row_r,   row_nxt;
  logic [COL_W-1:0] col_r,   col_nxt;
  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] prev_r,  prev_nxt;
  logic [IDX_W-1:0] base_r,  base_nxt;
  logic [IDX_W-1:0] vidx;
  logic             last;

  always_comb begin
    geom.textured = textured_r;
    if (slice_cnt_r < MIN_SLICES) begin
      geom.slices = MIN_SLICES;
    end else if (32'(slice_cnt_r) > SMAX) begin
      geom.slices = CFG_W'(SMAX);
    end else begin
      geom.slices = slice_cnt_r;
    end
    if (loop_cnt_r < MIN_LOOPS) begin
      geom.loops = MIN_LOOPS;
    end else if (32'(loop_cnt_r) > LMAX) begin
      geom.loops = CFG_W'(LMAX);
    end else begin
      geom.loops = loop_cnt_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_SLICE_COUNT ||
                                   cfg_index == REG_LOOP_COUNT ||
                                   cfg_index == REG_TEXTURED_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_cnt_r <= RST_SLICE_COUNT;
      loop_cnt_r  <= RST_LOOP_COUNT;
      textured_r  <= RST_TEXTURED_MODE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SLICE_COUNT:   slice_cnt_r <= cfg_data;
        REG_LOOP_COUNT:    loop_cnt_r  <= cfg_data;
        REG_TEXTURED_MODE: textured_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // output register frees up when empty or drained this cycle
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      restart_r <= in_tdata[0];
    end
  end

  ssig_step #(
    .ROW_W(ROW_W),
    .COL_W(COL_W)
  ) u_step (
    .geom      (geom),
    .restart   (restart_r),
    .row_r     (row_r),
    .col_r     (col_r),
    .phase_r   (phase_r),
    .prev_r    (prev_r),
    .base_r    (base_r),
    .row_nxt   (row_nxt),
    .col_nxt   (col_nxt),
    .phase_nxt (phase_nxt),
    .prev_nxt  (prev_nxt),
    .base_nxt  (base_nxt),
    .vidx      (vidx),
    .last      (last)
  );

  // a register write also returns the sequence to its start
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      row_r   <= '0;
      col_r   <= '0;
      phase_r <= PH_LEAD_TOP;
      prev_r  <= '0;
      base_r  <= '0;
    end else if (advance) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vidx_r <= vidx;
      last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24 - IDX_W){1'b0}}, vidx_r};
  assign out_tlast  = last_r;

  `SSIG_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !in_valid_r && !out_valid_r,
                      "pipeline not empty after reset")
  `SSIG_ASSERT(a_cfg_restarts, cfg_hit |=> phase_r == PH_LEAD_TOP && row_r == '0 && col_r == '0,
               "register write did not return the sequence to its start")
  `SSIG_ASSERT(a_last_restarts, advance && last |=> phase_r == PH_LEAD_TOP && row_r == '0,
               "sequence did not start over after the final index")
  `SSIG_ASSERT(a_out_from_input, $rose(out_valid_r) |-> $past(in_valid_r),
               "result beat appeared without a staged input beat")
  `SSIG_ASSERT(a_col_in_range, CW'(col_r) <= CW'(geom.slices),
               "slice column ran past the slice count")

endmodule

// File: tb/tb_sphere_strip_index_generator_unit.sv
`timescale 1ns / 100ps
module tb_sphere_strip_index_generator_unit;
  import ssig_pkg::*;

  localparam int MAX_SLICES   = 256;
  localparam int MAX_LOOPS    = 256;
  localparam int TARGET_ITEMS = 1850;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int IDLE_NONE   = 0;
  localparam int IDLE_FULL   = 1;
  localparam int IDLE_SPARSE = 2;

  localparam int WR_SLICES   = 1;
  localparam int WR_LOOPS    = 2;
  localparam int WR_TEXTURED = 4;
  localparam int WR_UNUSED   = 8;
  localparam int WR_ALL      = WR_SLICES | WR_LOOPS | WR_TEXTURED;

  typedef struct {
    logic restart;
    logic hold;
  } request_t;

  typedef struct {
    logic [IDX_W-1:0] vertex;
    logic             fin;
  } strip_index_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;  // [0] restart, [7:1] zero
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;        // [16:0] vertex_index, [23:17] zero
  logic                 out_tlast;        // last_index
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  sphere_strip_index_generator_unit #(
    .MAX_SLICES(MAX_SLICES),
    .MAX_LOOPS (MAX_LOOPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_t     strip_requests[$];
  strip_index_t expected_indices[$];

  // geometry registers and strip walker state as the block should hold them
  logic [CFG_W-1:0] slices_reg = RST_SLICE_COUNT;
  logic [CFG_W-1:0] loops_reg  = RST_LOOP_COUNT;
  logic             tex_reg    = RST_TEXTURED_MODE;
  phase_t           phase      = PH_LEAD_TOP;
  logic [7:0]       band       = '0;
  logic [8:0]       column     = '0;
  logic [IDX_W-1:0] prev_vertex = '0;
  logic [IDX_W-1:0] ring_base  = '0;

  int idle_style = IDLE_NONE;
  int in_wait    = 0;
  int out_wait   = 0;
  bit in_taken   = 1'b0;
  bit out_taken  = 1'b0;
  int quiet_cycles = 0;
  int mismatches   = 0;
  int n_requests   = 0;
  int n_indices    = 0;
  int n_strips     = 0;
  int n_reg_writes = 0;
  int n_phases     = 0;

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int eff_slices();
    return clamp(int'(slices_reg), int'(MIN_SLICES), MAX_SLICES);
  endfunction

  function automatic int eff_loops();
    return clamp(int'(loops_reg), int'(MIN_LOOPS), MAX_LOOPS);
  endfunction

  function automatic int strip_length(input int s_raw, input int l_raw);
    int s;
    int l;
    s = clamp(s_raw, int'(MIN_SLICES), MAX_SLICES);
    l = clamp(l_raw, int'(MIN_LOOPS), MAX_LOOPS);
    return (l - 1) * (2 * s + 4) - 2;
  endfunction

  // vertex on the upper ring of the current band
  function automatic int upper_ring(input int c);
    int s;
    s = eff_slices();
    if (tex_reg) return int'(ring_base) + s + 1 + c;
    if (int'(band) + 2 >= eff_loops()) return 1;
    return ((band == 0) ? 2 : int'(ring_base) + s) + c;
  endfunction

  // vertex on the lower ring of the current band
  function automatic int lower_ring(input int c);
    if (!tex_reg && band == 0) return 0;
    return int'(ring_base) + c;
  endfunction

  function automatic int draw_gap();
    case (idle_style)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 15);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  task automatic rewind_strip();
    band        = '0;
    column      = '0;
    phase       = PH_LEAD_TOP;
    prev_vertex = '0;
    ring_base   = '0;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
    case (idx)
      REG_SLICE_COUNT:   slices_reg = val;
      REG_LOOP_COUNT:    loops_reg  = val;
      REG_TEXTURED_MODE: tex_reg    = val[0];
      default:           return;
    endcase
    rewind_strip();
  endtask

  task automatic advance_strip(input logic restart);
    int           s;
    int           l;
    int           nxt;
    int           v;
    logic         fin;
    strip_index_t e;
    s   = eff_slices();
    l   = eff_loops();
    v   = 0;
    fin = 1'b0;
    if (restart) rewind_strip();
    nxt = int'(column) + 1;
    if (!tex_reg && nxt >= s) nxt = 0;
    case (phase)
      PH_LEAD_TOP: begin
        v     = upper_ring(0);
        phase = PH_LEAD_BOT;
      end
      PH_LEAD_BOT: begin
        v      = lower_ring(0);
        column = '0;
        phase  = PH_PAIR_TOP;
      end
      PH_PAIR_TOP: begin
        v     = upper_ring(nxt);
        phase = PH_PAIR_BOT;
      end
      PH_PAIR_BOT: begin
        v      = lower_ring(nxt);
        column = column + 1'b1;
        if (int'(column) >= s) begin
          if (int'(band) + 2 >= l) fin = 1'b1;
          else phase = PH_DEG_REP;
        end else begin
          phase = PH_PAIR_TOP;
        end
      end
      PH_DEG_REP: begin
        v     = int'(prev_vertex);
        phase = PH_DEG_NEXT;
      end
      default: begin
        // stitch to the next band and emit its lead top
        if (tex_reg) ring_base = IDX_W'(int'(ring_base) + s + 1);
        else ring_base = IDX_W'((band == 0) ? 2 : int'(ring_base) + s);
        band   = band + 1'b1;
        column = '0;
        v      = upper_ring(0);
        phase  = PH_LEAD_TOP;
      end
    endcase
    e.vertex    = IDX_W'(v);
    e.fin       = fin;
    prev_vertex = e.vertex;
    expected_indices.push_back(e);
    if (fin) rewind_strip();
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on result %0d, %s: expected %0d got %0d", n_indices, what, want, got);
  endtask

  // request driver
  always @(negedge clk) begin
    request_t req;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_tvalid) in_wait = draw_gap();
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (strip_requests.size() != 0 &&
                   !(strip_requests[0].hold && expected_indices.size() != 0)) begin
        req = strip_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, req.restart};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) out_wait = draw_gap();
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor, predictor and checker
  always @(posedge clk) begin
    strip_index_t want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        n_reg_writes++;
      end
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        n_requests++;
        advance_strip(in_tdata[0]);
      end
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        n_indices++;
        if (expected_indices.size() == 0) begin
          flag_mismatch("beat with nothing expected", 0, int'(out_tdata[IDX_W-1:0]));
        end else begin
          want = expected_indices.pop_front();
          if (out_tdata[IDX_W-1:0] !== want.vertex)
            flag_mismatch("vertex_index", int'(want.vertex), int'(out_tdata[IDX_W-1:0]));
          if (out_tdata[23:IDX_W] !== '0)
            flag_mismatch("tdata padding", 0, int'(out_tdata[23:IDX_W]));
          if (out_tlast !== want.fin)
            flag_mismatch("last_index", int'(want.fin), int'(out_tlast));
          if (want.fin) n_strips++;
        end
      end
      if (in_taken || out_taken || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_indices.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // wait until the block holds nothing, then let it drain
  task automatic settle();
    while (strip_requests.size() != 0 || in_tvalid || expected_indices.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic run_phase(input int s_raw, input int l_raw, input int tex, input int wr_mask,
                           input int n_items, input int restart_odds, input int style,
                           inout int total);
    request_t req;
    settle();
    idle_style = style;
    if (wr_mask & WR_SLICES)   write_reg(REG_SLICE_COUNT, CFG_W'(s_raw));
    if (wr_mask & WR_LOOPS)    write_reg(REG_LOOP_COUNT, CFG_W'(l_raw));
    if (wr_mask & WR_TEXTURED) write_reg(REG_TEXTURED_MODE, CFG_W'(tex));
    if (wr_mask & WR_UNUSED)   write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 511)));
    cfg_valid = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      req.restart = ($urandom_range(0, restart_odds - 1) == 0);
      req.hold    = ($urandom_range(0, 99) == 0);
      strip_requests.push_back(req);
    end
    total += n_items;
    n_phases++;
  endtask

  initial begin
    request_t req;
    int total;
    int s_raw;
    int l_raw;
    int len;
    int n;
    bit big;
    bit noisy;
    total = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: restart first, in mid band, back to back, and one drained pause
    idle_style = IDLE_SPARSE;
    for (int i = 0; i < 24; i++) begin
      req.restart = (i == 0 || i == 9 || i == 10 || i == 17);
      req.hold    = (i == 12);
      strip_requests.push_back(req);
    end
    total += 24;

    // clamp extremes and the smallest strips in both layouts, run to their end
    run_phase(0, 0, 0, WR_ALL, 60, 1000, IDLE_FULL, total);
    run_phase(2, 3, 1, WR_ALL, 60, 1000, IDLE_NONE, total);
    run_phase(3, 4, 0, WR_ALL | WR_UNUSED, 45, 1000, IDLE_SPARSE, total);
    // unused index mid strip must not rewind the walker
    run_phase(0, 0, 0, WR_UNUSED, 40, 1000, IDLE_FULL, total);
    run_phase(511, 511, 1, WR_ALL, 200, 1000, IDLE_SPARSE, total);
    run_phase(257, 4, 0, WR_ALL, 150, 1000, IDLE_NONE, total);
    run_phase(3, 256, 0, WR_SLICES | WR_LOOPS, 120, 1000, IDLE_FULL, total);
    run_phase(4, 5, 1, WR_ALL, 140, 1000, IDLE_SPARSE, total);
    // same value rewrite still rewinds
    run_phase(0, 0, 1, WR_TEXTURED, 50, 1000, IDLE_FULL, total);

    while (total < TARGET_ITEMS) begin
      big   = ($urandom_range(0, 7) == 0);
      noisy = ($urandom_range(0, 3) == 0);
      s_raw = big ? $urandom_range(0, 511) : $urandom_range(0, 9);
      l_raw = big ? $urandom_range(0, 511) : $urandom_range(0, 7);
      len   = strip_length(s_raw, l_raw);
      n     = big ? $urandom_range(50, 250) : $urandom_range(len, 3 * len);
      if (n > 400) n = 400;
      if (n > TARGET_ITEMS - total) n = TARGET_ITEMS - total;
      run_phase(s_raw, l_raw, $urandom_range(0, 1), $urandom_range(1, 15), n,
                noisy ? 5 : 300, $urandom_range(IDLE_NONE, IDLE_SPARSE), total);
    end

    settle();
    $display("covered %0d requests over %0d phases with %0d register writes,",
             n_requests, n_phases, n_reg_writes);
    $display("checked %0d indices including %0d complete strips, %0d mismatches",
             n_indices, n_strips, mismatches);
    if (mismatches == 0 && expected_indices.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
